@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL, used by the sequencer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/rmema_pkg.sv @@
// Types and constants of the rate meter
package rmema_pkg;

  localparam int CNT_W    = 16;
  localparam int DT_W     = 24;
  localparam int COUNT_W  = 40;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 48;
  localparam int ALPHA_W  = 17;
  localparam int Q_FRAC   = 16;
  localparam int MUL_W    = 20;
  localparam int PROD_W   = 60;
  localparam int ALU_W    = 66;
  localparam int STEP_W   = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [MUL_W-1:0]   US_PER_S       = 20'd1000000;
  localparam logic [RATE_W-1:0]  RATE_MAX       = {RATE_W{1'b1}};
  localparam logic [ALPHA_W-1:0] Q16_ONE        = 17'h10000;
  localparam logic [TIME_W-1:0]  MIN_UPDATE_RST = 32'd500000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST      = 17'd9830;

  localparam logic [STEP_W-1:0] MUL_STEPS = 6'd20;
  localparam logic [STEP_W-1:0] DIV_STEPS = 6'd48;
  localparam logic [STEP_W-1:0] EMA_STEPS = 6'd17;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_UPDATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 8'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_CNT,
    S_ACC_TIME,
    S_CHECK,
    S_MUL,
    S_SAT,
    S_DIV,
    S_DIFF,
    S_EMA,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic start;
    logic take;
  } ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } sts_t;

endpackage

@@ hw/rtl/item_rate_meter_ema_unit.sv @@
// Rate meter top level: handshakes, configuration registers, output word register
//
//   channel | signals                                         | dir
//   in      | in_valid, in_ready, item_count, time_delta_us   | in
//   out     | out_valid, out_ready, inst_rate, mean_rate      | out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | in
//
// A word with an update runs 20 multiply, 48 divide and 17 average steps on
// the shared 66-bit adder; a saturated rate skips the divide and a zero
// average skips the averaging. in_ready is high only while the sequencer
// is idle; one word at a time. The finished word waits in the output
// register; the sequencer waits in its final state while that register is
// full and out_ready is low. Synchronous reset restores the registers and
// clears the accumulators and average. cfg_ready is always high.
module item_rate_meter_ema_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [rmema_pkg::CNT_W-1:0]           item_count,
  input  logic [rmema_pkg::DT_W-1:0]            time_delta_us,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rmema_pkg::RATE_W-1:0]          inst_rate,
  output logic [rmema_pkg::RATE_W-1:0]          mean_rate,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rmema_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmema_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [rmema_pkg::TIME_W-1:0]  min_update_us;
  logic [rmema_pkg::ALPHA_W-1:0] alpha_q16;
  logic [rmema_pkg::ALPHA_W-1:0] alpha_eff;
  logic [rmema_pkg::RATE_W-1:0]  core_inst_rate, core_mean_rate;
  rmema_pkg::ctl_t               ctl;
  rmema_pkg::sts_t               sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_update_us <= rmema_pkg::MIN_UPDATE_RST;
      alpha_q16     <= rmema_pkg::ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rmema_pkg::REG_MIN_UPDATE) begin
        min_update_us <= cfg_data[rmema_pkg::TIME_W-1:0];
      end else if (cfg_index == rmema_pkg::REG_ALPHA) begin
        alpha_q16 <= cfg_data[rmema_pkg::ALPHA_W-1:0];
      end
    end
  end

  // weights above one count as one
  assign alpha_eff = (alpha_q16 > rmema_pkg::Q16_ONE) ? rmema_pkg::Q16_ONE : alpha_q16;

  assign in_ready  = sts.idle;
  assign ctl.start = in_valid && in_ready;
  assign ctl.take  = sts.done && (!out_valid || out_ready);

  rmema_core u_core (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .item_count    (item_count),
    .time_delta_us (time_delta_us),
    .min_update_us (min_update_us),
    .alpha         (alpha_eff),
    .inst_rate     (core_inst_rate),
    .mean_rate     (core_mean_rate)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      inst_rate <= core_inst_rate;
      mean_rate <= core_mean_rate;
    end
  end

endmodule

@@ hw/rtl/rmema_alu.sv @@
// Shared add/subtract unit of the rate meter
module rmema_alu (
  input  rmema_pkg::alu_op_t           op,
  input  logic [rmema_pkg::ALU_W-1:0]  a,
  input  logic [rmema_pkg::ALU_W-1:0]  b,
  output logic [rmema_pkg::ALU_W-1:0]  y
);

  always_comb begin
    case (op)
      rmema_pkg::ALU_ADD: y = a + b;
      rmema_pkg::ALU_SUB: y = a - b;
      default:            y = a + b;
    endcase
  end

endmodule

@@ hw/rtl/rmema_core.sv @@
// Sequencer and datapath: accumulate, multiply, divide and average
`include "assert_macros.svh"

module rmema_core (
  input  logic                              clk,
  input  logic                              rst,
  input  rmema_pkg::ctl_t                   ctl,
  output rmema_pkg::sts_t                   sts,
  input  logic [rmema_pkg::CNT_W-1:0]       item_count,
  input  logic [rmema_pkg::DT_W-1:0]        time_delta_us,
  input  logic [rmema_pkg::TIME_W-1:0]      min_update_us,
  input  logic [rmema_pkg::ALPHA_W-1:0]     alpha,
  output logic [rmema_pkg::RATE_W-1:0]      inst_rate,
  output logic [rmema_pkg::RATE_W-1:0]      mean_rate
);

  localparam int ALU_W   = rmema_pkg::ALU_W;
  localparam int COUNT_W = rmema_pkg::COUNT_W;
  localparam int TIME_W  = rmema_pkg::TIME_W;
  localparam int RATE_W  = rmema_pkg::RATE_W;
  localparam int PROD_W  = rmema_pkg::PROD_W;
  localparam int Q_FRAC  = rmema_pkg::Q_FRAC;
  localparam int HIGH_W  = PROD_W - RATE_W;

  rmema_pkg::state_t state, state_next;

  logic [COUNT_W-1:0]             count_accum, count_accum_next;
  logic [TIME_W-1:0]              time_accum, time_accum_next;
  logic [RATE_W-1:0]              avg_rate, avg_rate_next;
  logic [rmema_pkg::CNT_W-1:0]    cnt_in, cnt_in_next;
  logic [rmema_pkg::DT_W-1:0]     dt_in, dt_in_next;
  logic [ALU_W-1:0]               acc, acc_next;
  logic [ALU_W-1:0]               mc, mc_next;
  logic [TIME_W-1:0]              rem, rem_next;
  logic [RATE_W-1:0]              quo, quo_next;
  logic [rmema_pkg::STEP_W-1:0]   step, step_next;

  rmema_pkg::alu_op_t alu_op;
  logic [ALU_W-1:0]   alu_a, alu_b, alu_y;
  logic               borrow;

  rmema_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign borrow = alu_y[ALU_W-1];

  always_comb begin
    alu_op = rmema_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      rmema_pkg::S_ACC_CNT: begin
        alu_a = {{(ALU_W-COUNT_W){1'b0}}, count_accum};
        alu_b = {{(ALU_W-rmema_pkg::CNT_W){1'b0}}, cnt_in};
      end
      rmema_pkg::S_ACC_TIME: begin
        alu_a = {{(ALU_W-TIME_W){1'b0}}, time_accum};
        alu_b = {{(ALU_W-rmema_pkg::DT_W){1'b0}}, dt_in};
      end
      rmema_pkg::S_CHECK: begin
        alu_op = rmema_pkg::ALU_SUB;
        alu_a  = {{(ALU_W-TIME_W){1'b0}}, time_accum};
        alu_b  = {{(ALU_W-TIME_W){1'b0}}, min_update_us};
      end
      rmema_pkg::S_MUL: begin
        alu_a = acc;
        alu_b = rmema_pkg::US_PER_S[step[4:0]] ? mc : '0;
      end
      rmema_pkg::S_SAT: begin
        alu_op = rmema_pkg::ALU_SUB;
        alu_a  = {{(ALU_W-HIGH_W){1'b0}}, acc[PROD_W-1:RATE_W]};
        alu_b  = {{(ALU_W-TIME_W){1'b0}}, time_accum};
      end
      rmema_pkg::S_DIV: begin
        alu_op = rmema_pkg::ALU_SUB;
        alu_a  = {{(ALU_W-TIME_W-1){1'b0}}, rem, quo[RATE_W-1]};
        alu_b  = {{(ALU_W-TIME_W){1'b0}}, time_accum};
      end
      rmema_pkg::S_DIFF: begin
        alu_op = rmema_pkg::ALU_SUB;
        alu_a  = {{(ALU_W-RATE_W){1'b0}}, quo};
        alu_b  = {{(ALU_W-RATE_W){1'b0}}, avg_rate};
      end
      rmema_pkg::S_EMA: begin
        alu_a = acc;
        alu_b = alpha[step[4:0]] ? mc : '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    count_accum_next = count_accum;
    time_accum_next  = time_accum;
    avg_rate_next    = avg_rate;
    cnt_in_next      = cnt_in;
    dt_in_next       = dt_in;
    acc_next         = acc;
    mc_next          = mc;
    rem_next         = rem;
    quo_next         = quo;
    step_next        = step;
    case (state)
      rmema_pkg::S_IDLE: begin
        if (ctl.start) begin
          cnt_in_next = item_count;
          dt_in_next  = time_delta_us;
          state_next  = rmema_pkg::S_ACC_CNT;
        end
      end
      rmema_pkg::S_ACC_CNT: begin
        count_accum_next = (|alu_y[ALU_W-1:COUNT_W]) ? {COUNT_W{1'b1}} : alu_y[COUNT_W-1:0];
        state_next       = rmema_pkg::S_ACC_TIME;
      end
      rmema_pkg::S_ACC_TIME: begin
        time_accum_next = (|alu_y[ALU_W-1:TIME_W]) ? {TIME_W{1'b1}} : alu_y[TIME_W-1:0];
        state_next      = rmema_pkg::S_CHECK;
      end
      rmema_pkg::S_CHECK: begin
        if ((time_accum != '0) && !borrow) begin
          acc_next   = '0;
          mc_next    = {{(ALU_W-COUNT_W){1'b0}}, count_accum};
          step_next  = '0;
          state_next = rmema_pkg::S_MUL;
        end else begin
          state_next = rmema_pkg::S_IDLE;
        end
      end
      rmema_pkg::S_MUL: begin
        acc_next  = alu_y;
        mc_next   = {mc[ALU_W-2:0], 1'b0};
        step_next = step + 1'b1;
        if (step == rmema_pkg::MUL_STEPS - 1'b1) begin
          state_next = rmema_pkg::S_SAT;
        end
      end
      rmema_pkg::S_SAT: begin
        // quotient would need more than 48 bits
        if (!borrow) begin
          quo_next   = rmema_pkg::RATE_MAX;
          state_next = rmema_pkg::S_DIFF;
        end else begin
          rem_next   = {{(TIME_W-HIGH_W){1'b0}}, acc[PROD_W-1:RATE_W]};
          quo_next   = acc[RATE_W-1:0];
          step_next  = '0;
          state_next = rmema_pkg::S_DIV;
        end
      end
      rmema_pkg::S_DIV: begin
        if (!borrow) begin
          rem_next = alu_y[TIME_W-1:0];
        end else begin
          rem_next = {rem[TIME_W-2:0], quo[RATE_W-1]};
        end
        quo_next  = {quo[RATE_W-2:0], !borrow};
        step_next = step + 1'b1;
        if (step == rmema_pkg::DIV_STEPS - 1'b1) begin
          state_next = rmema_pkg::S_DIFF;
        end
      end
      rmema_pkg::S_DIFF: begin
        count_accum_next = '0;
        time_accum_next  = '0;
        if (avg_rate == '0) begin
          avg_rate_next = quo;
          state_next    = rmema_pkg::S_DONE;
        end else begin
          // avg*1.0 + alpha*(rate - avg), signed difference
          acc_next   = {{(ALU_W-RATE_W-Q_FRAC){1'b0}}, avg_rate, {Q_FRAC{1'b0}}};
          mc_next    = alu_y;
          step_next  = '0;
          state_next = rmema_pkg::S_EMA;
        end
      end
      rmema_pkg::S_EMA: begin
        acc_next  = alu_y;
        mc_next   = {mc[ALU_W-2:0], 1'b0};
        step_next = step + 1'b1;
        if (step == rmema_pkg::EMA_STEPS - 1'b1) begin
          avg_rate_next = alu_y[Q_FRAC+RATE_W-1:Q_FRAC];
          state_next    = rmema_pkg::S_DONE;
        end
      end
      rmema_pkg::S_DONE: begin
        if (ctl.take) begin
          state_next = rmema_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rmema_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rmema_pkg::S_IDLE;
      step        <= '0;
      count_accum <= '0;
      time_accum  <= '0;
      avg_rate    <= '0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      count_accum <= count_accum_next;
      time_accum  <= time_accum_next;
      avg_rate    <= avg_rate_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt_in <= cnt_in_next;
    dt_in  <= dt_in_next;
    acc    <= acc_next;
    mc     <= mc_next;
    rem    <= rem_next;
    quo    <= quo_next;
  end

  assign sts.idle  = (state == rmema_pkg::S_IDLE);
  assign sts.done  = (state == rmema_pkg::S_DONE);
  assign inst_rate = quo;
  assign mean_rate = avg_rate;

  `ASSERT_NOW(a_start_idle, ctl.start, state == rmema_pkg::S_IDLE)
  `ASSERT_NOW(a_rem_below_divisor, state == rmema_pkg::S_DIV, rem < time_accum)
  `ASSERT_NOW(a_div_step_range, state == rmema_pkg::S_DIV, step < rmema_pkg::DIV_STEPS)
  `ASSERT_NOW(a_accum_cleared, state == rmema_pkg::S_DONE, (count_accum == '0) && (time_accum == '0))
  `ASSERT_NOW(a_avg_nonzero, (state == rmema_pkg::S_DONE) && (quo != '0), avg_rate != '0)
  `ASSERT_NEXT(a_take_to_idle, (state == rmema_pkg::S_DONE) && ctl.take, state == rmema_pkg::S_IDLE)

endmodule

@@ verif/item_rate_meter_ema_unit_test.sv @@
// Self-checking testbench for the rate meter with its moving average
module item_rate_meter_ema_unit_test;

  localparam int CNT_W      = rmema_pkg::CNT_W;
  localparam int DT_W       = rmema_pkg::DT_W;
  localparam int COUNT_W    = rmema_pkg::COUNT_W;
  localparam int TIME_W     = rmema_pkg::TIME_W;
  localparam int RATE_W     = rmema_pkg::RATE_W;
  localparam int ALPHA_W    = rmema_pkg::ALPHA_W;
  localparam int Q_FRAC     = rmema_pkg::Q_FRAC;
  localparam int CFG_IDX_W  = rmema_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rmema_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_LEN    = 1500;
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned BURST_LEN   = 40;

  typedef struct packed {
    bit [CNT_W-1:0] cnt;
    bit [DT_W-1:0]  dt;
  } report_t;

  typedef struct packed {
    bit [RATE_W-1:0] inst;
    bit [RATE_W-1:0] avg;
  } rate_pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CNT_W-1:0]      item_count = '0;
  logic [DT_W-1:0]       time_delta_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RATE_W-1:0]     inst_rate;
  logic [RATE_W-1:0]     mean_rate;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  item_rate_meter_ema_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .item_count(item_count), .time_delta_us(time_delta_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .inst_rate(inst_rate), .mean_rate(mean_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  report_t     report_q[$];
  rate_pair_t  rate_expect[$];
  report_t     next_report;
  rate_pair_t  seen;
  logic        in_fire = 1'b0;
  logic        calm = 1'b0;
  logic        hold_armed = 1'b0;
  logic        hold_spent = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;

  // predictor state
  bit [COUNT_W-1:0] acc_items;
  bit [TIME_W-1:0]  acc_us;
  bit [RATE_W-1:0]  ema_rate;
  bit [TIME_W-1:0]  thresh_us;
  bit [ALPHA_W-1:0] weight_q16;

  function automatic void track_report(input bit [CNT_W-1:0] cnt, input bit [DT_W-1:0] dt);
    bit [COUNT_W:0]   csum;
    bit [TIME_W:0]    tsum;
    bit [63:0]        quot;
    bit [RATE_W-1:0]  inst;
    bit [ALPHA_W-1:0] a;
    bit [64:0]        mix;
    rate_pair_t       pair;
    csum = {1'b0, acc_items} + cnt;
    acc_items = csum[COUNT_W] ? {COUNT_W{1'b1}} : csum[COUNT_W-1:0];
    tsum = {1'b0, acc_us} + dt;
    acc_us = tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
    if (acc_us == 0 || acc_us < thresh_us) return;
    quot = ({24'b0, acc_items} * {44'b0, rmema_pkg::US_PER_S}) / {32'b0, acc_us};
    inst = (quot > {16'b0, rmema_pkg::RATE_MAX}) ? rmema_pkg::RATE_MAX : quot[RATE_W-1:0];
    acc_items = '0;
    acc_us = '0;
    if (ema_rate == 0) begin
      ema_rate = inst;
    end else begin
      a = (weight_q16 > rmema_pkg::Q16_ONE) ? rmema_pkg::Q16_ONE : weight_q16;
      mix = {17'b0, inst} * {48'b0, a}
            + {17'b0, ema_rate} * {48'b0, rmema_pkg::Q16_ONE - a};
      ema_rate = mix[Q_FRAC+RATE_W-1:Q_FRAC];
    end
    pair.inst = inst;
    pair.avg = ema_rate;
    rate_expect.push_back(pair);
  endfunction

  // accepted words and register writes feed the predictor
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (rst) begin
      acc_items = '0;
      acc_us = '0;
      ema_rate = '0;
      thresh_us = rmema_pkg::MIN_UPDATE_RST;
      weight_q16 = rmema_pkg::ALPHA_RST;
    end else begin
      if (in_valid && in_ready) track_report(item_count, time_delta_us);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rmema_pkg::REG_MIN_UPDATE) thresh_us = cfg_data[TIME_W-1:0];
        else if (cfg_index == rmema_pkg::REG_ALPHA) weight_q16 = cfg_data[ALPHA_W-1:0];
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (report_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
        next_report = report_q.pop_front();
        in_valid <= 1'b1;
        item_count <= next_report.cnt;
        time_delta_us <= next_report.dt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_spent) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) hold_spent <= 1'b1;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 24;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (rate_expect.size() == 0) begin
        mismatches <= mismatches + 1;
        $display("%0t: unexpected word inst_rate=%0d mean_rate=%0d", $time, inst_rate,
                 mean_rate);
      end else begin
        seen = rate_expect.pop_front();
        if (inst_rate !== seen.inst || mean_rate !== seen.avg) mismatches <= mismatches + 1;
        if (inst_rate !== seen.inst)
          $display("%0t: inst_rate expected %0d actual %0d", $time, seen.inst, inst_rate);
        if (mean_rate !== seen.avg)
          $display("%0t: mean_rate expected %0d actual %0d", $time, seen.avg, mean_rate);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic offer(input int unsigned cnt, input int unsigned dt);
    report_t r;
    r.cnt = cnt[CNT_W-1:0];
    r.dt = dt[DT_W-1:0];
    report_q.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every word to go in and every rate word to come out
  task automatic drain();
    while (report_q.size() != 0 || in_valid || rate_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [31:0] thr, input logic [31:0] alpha,
                              input int unsigned n, input int unsigned span,
                              input int unsigned full_pct, input logic quiet);
    int unsigned c;
    int unsigned d;
    int unsigned p;
    calm = quiet;
    write_reg(rmema_pkg::REG_MIN_UPDATE, thr);
    write_reg(rmema_pkg::REG_ALPHA, alpha);
    repeat (n) begin
      p = $urandom_range(9);
      c = (p == 0) ? 0 : (p == 1) ? 32'hFFFF : $urandom_range(32'hFFFF);
      p = $urandom_range(99);
      if (p < full_pct) d = 24'hFFFFFF;
      else if (p < full_pct + 8) d = 0;
      else d = $urandom_range(span);
      offer(c, d);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero time, full word, just under and exactly at threshold
    offer(0, 0);
    offer(16'hFFFF, 24'hFFFFFF);
    offer(1, 499999);
    offer(0, 1);
    offer(0, 500000);
    offer(12345, 250000);
    offer(0, 250000);
    drain();

    // zero threshold, full weight
    write_reg(rmema_pkg::REG_MIN_UPDATE, 32'd0);
    write_reg(rmema_pkg::REG_ALPHA, {15'b0, rmema_pkg::Q16_ONE});
    offer(5, 0);
    offer(5, 1);
    offer(16'hFFFF, 1);
    offer(0, 0);
    offer(0, 7);
    offer(300, 3);
    drain();

    // weight above one, spare indexes must be ignored
    write_reg(rmema_pkg::REG_MIN_UPDATE, 32'd1);
    write_reg(rmema_pkg::REG_ALPHA, 32'hFFFFFFFF);
    write_reg(REG_SPARE_LO, 32'd0);
    write_reg(REG_SPARE_HI, 32'd0);
    offer(100, 1);
    offer(200, 2);
    offer(1, 0);
    offer(7, 24'hFFFFFF);
    offer(16'hFFFF, 24'h800000);
    drain();

    // count piles up with no time, then one microsecond
    write_reg(rmema_pkg::REG_ALPHA, 32'd0);
    repeat (BURST_LEN) offer(16'hFFFF, 0);
    offer(16'hFFFF, 1);
    offer(1000, 3);
    drain();

    hold_armed = 1'b1;
    random_phase(32'd0, $urandom_range(32'h10000), 100, 4000, 0, 1'b0);
    random_phase($urandom_range(200000, 1000), $urandom_range(32'h10000), 100, 50000, 2,
                 1'b1);
    random_phase(32'hFFFFFFFF, {15'b0, rmema_pkg::Q16_ONE}, 280, 24'hFFFFFF, 90, 1'b0);
    random_phase(rmema_pkg::MIN_UPDATE_RST, {15'b0, rmema_pkg::ALPHA_RST}, 80, 400000, 3,
                 1'b0);
    random_phase($urandom(), $urandom_range(32'h1FFFF, 32'h10001), 50, 24'hFFFFFF, 10, 1'b0);
    random_phase($urandom_range(30), $urandom_range(32'h10000), 60, 40, 0, 1'b0);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
